// File: rtl/rrrob_pkg.sv
// ----------------------------------------------------------------------------
// rrrob_pkg
// Shared constants, codes and types of the rename and reorder unit.
// ----------------------------------------------------------------------------
package rrrob_pkg;

  localparam int ARCH_REGS  = 32;
  localparam int PREG_MAX   = 64;
  localparam int ROB_DEPTH  = 64;
  localparam int TOTAL_REGS = ARCH_REGS + PREG_MAX;

  localparam int AREG_W = 5;
  localparam int PREG_W = 7;
  localparam int ROB_W  = 6;
  localparam int CNT_W  = 7;
  localparam int PIDX_W = $clog2(PREG_MAX);
  localparam int GRP    = 8;
  localparam int NGRP   = PREG_MAX / GRP;
  localparam int GIDX_W = $clog2(GRP);
  localparam int RENT_W = PREG_W + 3;

  localparam logic [1:0] CMD_DISPATCH = 2'd0;
  localparam logic [1:0] CMD_COMPLETE = 2'd1;
  localparam logic [1:0] CMD_RETIRE   = 2'd2;

  localparam logic [1:0] STALL_NONE = 2'd0;
  localparam logic [1:0] STALL_ROB  = 2'd1;
  localparam logic [1:0] STALL_PREG = 2'd2;

  localparam logic REG_ROB_CAP  = 1'b0;
  localparam logic REG_PREG_CNT = 1'b1;

  localparam logic [1:0] ASEL_SRC1 = 2'd0;
  localparam logic [1:0] ASEL_SRC2 = 2'd1;
  localparam logic [1:0] ASEL_DEST = 2'd2;

  localparam logic [CNT_W-1:0] CFG_RST = CNT_W'(64);
  localparam logic [TOTAL_REGS-1:0] READY_RST = {{PREG_MAX{1'b0}}, {ARCH_REGS{1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_DRD1, ST_DRD2, ST_DRD3, ST_DFIN, ST_CFIN, ST_RCHK, ST_RPOP
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       alias_rd;
    logic [1:0] alias_sel;
    logic       search1;
    logic       search2;
    logic       cap_s1;
    logic       cap_s2;
    logic       disp_fin;
    logic       cmpl_fin;
    logic       rt_start;
    logic       rt_read;
    logic       rt_pop;
    logic       rt_fin;
  } ctl_t;

  typedef struct packed {
    logic rt_more;
  } sts_t;

endpackage

// File: rtl/rrrob_ctrl.sv
// ----------------------------------------------------------------------------
// rrrob_ctrl
// Sequencer of the rename and reorder unit and owner of the result valid.
// ----------------------------------------------------------------------------
module rrrob_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     cmd,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  rrrob_pkg::sts_t sts,
  output rrrob_pkg::ctl_t ctl
);
  import rrrob_pkg::*;

  state_t state, state_next;
  logic   out_free;
  logic   load;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign load     = ctl.disp_fin || ctl.cmpl_fin || ctl.rt_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_DISPATCH: state_next = ST_DRD1;
            CMD_RETIRE:   state_next = ST_RCHK;
            default:      state_next = ST_CFIN;
          endcase
        end
      end
      ST_DRD1: state_next = ST_DRD2;
      ST_DRD2: state_next = ST_DRD3;
      ST_DRD3: state_next = ST_DFIN;
      ST_DFIN: if (out_free) state_next = ST_IDLE;
      ST_CFIN: if (out_free) state_next = ST_IDLE;
      ST_RCHK: begin
        if (sts.rt_more) begin
          state_next = ST_RPOP;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RPOP: state_next = ST_RCHK;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: begin
        ctl.capture  = in_valid;
        ctl.rt_start = in_valid && (cmd == CMD_RETIRE);
      end
      ST_DRD1: begin
        ctl.alias_rd  = 1'b1;
        ctl.alias_sel = ASEL_SRC1;
        ctl.search1   = 1'b1;
      end
      ST_DRD2: begin
        ctl.alias_rd  = 1'b1;
        ctl.alias_sel = ASEL_SRC2;
        ctl.search2   = 1'b1;
        ctl.cap_s1    = 1'b1;
      end
      ST_DRD3: begin
        ctl.alias_rd  = 1'b1;
        ctl.alias_sel = ASEL_DEST;
        ctl.cap_s2    = 1'b1;
      end
      ST_DFIN: ctl.disp_fin = out_free;
      ST_CFIN: ctl.cmpl_fin = out_free;
      ST_RCHK: begin
        ctl.rt_read = sts.rt_more;
        ctl.rt_fin  = !sts.rt_more && out_free;
      end
      ST_RPOP: ctl.rt_pop = 1'b1;
      default: ctl = '0;
    endcase
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("item taken while busy");
  a_one_finish: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.disp_fin, ctl.cmpl_fin, ctl.rt_fin})) else $error("two finishes");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load) else $error("waiting result overwritten");
  a_pop_after_read: assert property (@(posedge clk) disable iff (rst)
    ctl.rt_pop |-> $past(ctl.rt_read)) else $error("pop without read");

endmodule

// File: rtl/rrrob_dp.sv
// ----------------------------------------------------------------------------
// rrrob_dp
// Datapath: alias table, register pool, reorder buffer, settings, result.
// ----------------------------------------------------------------------------
module rrrob_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  rrrob_pkg::ctl_t               ctl,
  output rrrob_pkg::sts_t               sts,
  input  logic [1:0]                    cmd,
  input  logic                          dest_valid,
  input  logic [rrrob_pkg::AREG_W-1:0]  dest_areg,
  input  logic                          src1_valid,
  input  logic [rrrob_pkg::AREG_W-1:0]  src1_areg,
  input  logic                          src2_valid,
  input  logic [rrrob_pkg::AREG_W-1:0]  src2_areg,
  input  logic                          is_branch,
  input  logic                          mispredicted,
  input  logic [rrrob_pkg::ROB_W-1:0]   done_rob_index,
  input  logic                          done_preg_valid,
  input  logic [rrrob_pkg::PREG_W-1:0]  done_preg,
  input  logic                          cfg_we,
  input  logic                          cfg_sel,
  input  logic [rrrob_pkg::CNT_W-1:0]   cfg_wdata,
  output logic [31:0]                   cfg_rdata,
  output logic                          accepted,
  output logic [1:0]                    stall_reason,
  output logic [rrrob_pkg::PREG_W-1:0]  src1_preg,
  output logic [rrrob_pkg::PREG_W-1:0]  src2_preg,
  output logic [rrrob_pkg::PREG_W-1:0]  dest_preg,
  output logic [rrrob_pkg::ROB_W-1:0]   rob_slot,
  output logic [rrrob_pkg::CNT_W-1:0]   retired_count,
  output logic [rrrob_pkg::CNT_W-1:0]   retired_branches,
  output logic                          mispredict_retired,
  output logic [rrrob_pkg::CNT_W-1:0]   rob_occupancy
);
  import rrrob_pkg::*;

  // Captured item.
  logic [1:0]        cmd_q;
  logic              dv_q, s1v_q, s2v_q, br_q, mis_q, dpv_q;
  logic [AREG_W-1:0] da_q, a1_q, a2_q;
  logic [ROB_W-1:0]  di_q;
  logic [PREG_W-1:0] dp_q;

  logic [CNT_W-1:0] rob_capacity, preg_count, cap, pc;

  logic [PREG_W-1:0]     amem [ARCH_REGS];
  logic [ARCH_REGS-1:0]  aval;
  logic [PREG_W-1:0]     amem_q;
  logic                  aval_q;
  logic [AREG_W-1:0]     aidx_q, araddr;
  logic [PREG_W-1:0]     alias_val;
  logic [PREG_W-1:0]     s1_q, s2_q;

  logic [PREG_MAX-1:0]   free_bits;
  logic [TOTAL_REGS-1:0] ready_bits;
  logic [PREG_MAX-1:0]   cand;
  logic [NGRP-1:0]       grp_any;
  logic [GIDX_W-1:0]     grp_idx   [NGRP];
  logic [GIDX_W-1:0]     grp_idx_c [NGRP];
  logic                  found_any, found_any_c;
  logic [PIDX_W-1:0]     found_idx, found_idx_c;
  logic [PREG_W-1:0]     found_preg;

  logic [RENT_W-1:0]     rmem [ROB_DEPTH];
  logic [RENT_W-1:0]     rent_q;
  logic [ROB_DEPTH-1:0]  done_bits;
  logic [ROB_W-1:0]      head, tail, head_inc, tail_inc, off;
  logic [CNT_W-1:0]      used, rcount, rbr;
  logic                  rmis;

  logic full, disp_ok, has_dest;
  logic [PREG_W-1:0] prev, rprev;
  logic rhas, rbranch, rmisp;

  assign cap = (rob_capacity > CNT_W'(ROB_DEPTH)) ? CNT_W'(ROB_DEPTH) : rob_capacity;
  assign pc  = (preg_count > CNT_W'(PREG_MAX)) ? CNT_W'(PREG_MAX) : preg_count;
  assign cfg_rdata = {{(32-CNT_W){1'b0}}, (cfg_sel == REG_PREG_CNT) ? preg_count : rob_capacity};

  assign head_inc = (head == ROB_W'(ROB_DEPTH-1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == ROB_W'(ROB_DEPTH-1)) ? '0 : tail + 1'b1;
  assign off      = di_q - head;

  assign alias_val  = aval_q ? amem_q : {{(PREG_W-AREG_W){1'b0}}, aidx_q};
  assign found_preg = PREG_W'(ARCH_REGS) + PREG_W'(found_idx);
  assign has_dest   = dv_q;
  assign full       = (used >= cap);
  assign disp_ok    = !full && !(has_dest && !found_any);
  assign prev       = has_dest ? alias_val : '0;
  assign {rprev, rhas, rbranch, rmisp} = rent_q;

  assign sts.rt_more = (used != '0) && done_bits[head] && !rmis;

  always_comb begin
    case (ctl.alias_sel)
      ASEL_SRC1: araddr = a1_q;
      ASEL_SRC2: araddr = a2_q;
      default:   araddr = da_q;
    endcase
  end

  // Lowest free register: groups of eight, then the lowest group.
  always_comb begin
    for (int j = 0; j < PREG_MAX; j++) begin
      cand[j] = free_bits[j] && (CNT_W'(j) < pc);
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_idx_c[g] = '0;
      for (int b = GRP-1; b >= 0; b--) begin
        if (cand[g*GRP+b]) grp_idx_c[g] = GIDX_W'(b);
      end
    end
    found_any_c = |grp_any;
    found_idx_c = '0;
    for (int g = NGRP-1; g >= 0; g--) begin
      if (grp_any[g]) found_idx_c = PIDX_W'(g*GRP) + PIDX_W'(grp_idx[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.search1) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_any[g] <= |cand[g*GRP +: GRP];
        grp_idx[g] <= grp_idx_c[g];
      end
    end
    if (ctl.search2) begin
      found_any <= found_any_c;
      found_idx <= found_idx_c;
    end
  end

  // Item capture and alias reads.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= cmd;
      dv_q  <= dest_valid;
      da_q  <= dest_areg;
      s1v_q <= src1_valid;
      a1_q  <= src1_areg;
      s2v_q <= src2_valid;
      a2_q  <= src2_areg;
      br_q  <= is_branch;
      mis_q <= is_branch && mispredicted;
      di_q  <= done_rob_index;
      dpv_q <= done_preg_valid;
      dp_q  <= done_preg;
    end
    if (ctl.alias_rd) begin
      amem_q <= amem[araddr];
      aval_q <= aval[araddr];
      aidx_q <= araddr;
    end
    if (ctl.cap_s1) s1_q <= s1v_q ? alias_val : '0;
    if (ctl.cap_s2) s2_q <= s2v_q ? alias_val : '0;
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (ctl.disp_fin && disp_ok && has_dest) begin
      amem[da_q] <= found_preg;
    end
    if (ctl.disp_fin && disp_ok) begin
      rmem[tail] <= {prev, has_dest, br_q, mis_q};
    end
    if (ctl.rt_read) begin
      rent_q <= rmem[head];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rob_capacity <= CFG_RST;
      preg_count   <= CFG_RST;
      aval         <= '0;
      free_bits    <= '1;
      ready_bits   <= READY_RST;
      done_bits    <= '0;
      head         <= '0;
      tail         <= '0;
      used         <= '0;
      rcount       <= '0;
      rbr          <= '0;
      rmis         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == REG_PREG_CNT) begin
          preg_count <= cfg_wdata;
        end else begin
          rob_capacity <= cfg_wdata;
        end
      end
      if (ctl.disp_fin && disp_ok) begin
        if (has_dest) begin
          aval[da_q]                      <= 1'b1;
          free_bits[found_idx]            <= 1'b0;
          ready_bits[found_preg]          <= 1'b0;
        end
        done_bits[tail] <= 1'b0;
        tail            <= tail_inc;
        used            <= used + 1'b1;
      end
      if (ctl.cmpl_fin && (cmd_q == CMD_COMPLETE)) begin
        if (dpv_q && (dp_q < PREG_W'(TOTAL_REGS))) begin
          ready_bits[dp_q] <= 1'b1;
        end
        if (CNT_W'(off) < used) begin
          done_bits[di_q] <= 1'b1;
        end
      end
      if (ctl.rt_start) begin
        rcount <= '0;
        rbr    <= '0;
        rmis   <= 1'b0;
      end
      if (ctl.rt_pop) begin
        head   <= head_inc;
        used   <= used - 1'b1;
        rcount <= rcount + 1'b1;
        if (rbranch) rbr <= rbr + 1'b1;
        if (rbranch && rmisp) begin
          rmis       <= 1'b1;
          aval       <= '0;
          free_bits  <= '1;
          ready_bits <= READY_RST;
        end else if (rhas && (rprev >= PREG_W'(ARCH_REGS)) &&
                     (rprev < PREG_W'(TOTAL_REGS))) begin
          free_bits[PIDX_W'(rprev - PREG_W'(ARCH_REGS))] <= 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.disp_fin || ctl.cmpl_fin || ctl.rt_fin) begin
      accepted           <= 1'b0;
      stall_reason       <= STALL_NONE;
      src1_preg          <= '0;
      src2_preg          <= '0;
      dest_preg          <= '0;
      rob_slot           <= '0;
      retired_count      <= '0;
      retired_branches   <= '0;
      mispredict_retired <= 1'b0;
      rob_occupancy      <= used;
      if (ctl.disp_fin) begin
        if (full) begin
          stall_reason <= STALL_ROB;
        end else if (!disp_ok) begin
          stall_reason <= STALL_PREG;
        end else begin
          accepted      <= 1'b1;
          src1_preg     <= s1_q;
          src2_preg     <= s2_q;
          dest_preg     <= has_dest ? found_preg : '0;
          rob_slot      <= tail;
          rob_occupancy <= used + 1'b1;
        end
      end
      if (ctl.rt_fin) begin
        retired_count      <= rcount;
        retired_branches   <= rbr;
        mispredict_retired <= rmis;
      end
    end
  end

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(ROB_DEPTH)) else $error("reorder count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.rt_pop |-> (used != '0)) else $error("pop from empty buffer");
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.disp_fin && disp_ok && has_dest) |-> free_bits[found_idx])
    else $error("allocated register not free");

endmodule

// File: rtl/register_rename_reorder_buffer_core.sv
// ----------------------------------------------------------------------------
// register_rename_reorder_buffer_core
// Register rename and reorder unit: dispatch, completion and in-order retire.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Contents
//   input     in         in_valid / in_stall   one command item (cmd and fields)
//   output    out        out_valid / out_stall one result item per command
//   config    in/out     APB psel / penable    rob_capacity at 0, preg_count at 4
//
// In a dispatch the alias table has one read port, so the two
// sources and the old destination mapping are read in turn while a two-stage
// search finds the lowest free physical register. A retire reads each entry it
// pops from the single-port reorder memory before that entry is applied.
// Reset is synchronous; the reorder memory needs no clearing pass. A new item is
// taken while the previous result still waits on a stalled output; the next
// result waits until that register is free.
module register_rename_reorder_buffer_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   cmd,
  input  logic                         dest_valid,
  input  logic [rrrob_pkg::AREG_W-1:0] dest_areg,
  input  logic                         src1_valid,
  input  logic [rrrob_pkg::AREG_W-1:0] src1_areg,
  input  logic                         src2_valid,
  input  logic [rrrob_pkg::AREG_W-1:0] src2_areg,
  input  logic                         is_branch,
  input  logic                         mispredicted,
  input  logic [rrrob_pkg::ROB_W-1:0]  done_rob_index,
  input  logic                         done_preg_valid,
  input  logic [rrrob_pkg::PREG_W-1:0] done_preg,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         accepted,
  output logic [1:0]                   stall_reason,
  output logic [rrrob_pkg::PREG_W-1:0] src1_preg,
  output logic [rrrob_pkg::PREG_W-1:0] src2_preg,
  output logic [rrrob_pkg::PREG_W-1:0] dest_preg,
  output logic [rrrob_pkg::ROB_W-1:0]  rob_slot,
  output logic [rrrob_pkg::CNT_W-1:0]  retired_count,
  output logic [rrrob_pkg::CNT_W-1:0]  retired_branches,
  output logic                         mispredict_retired,
  output logic [rrrob_pkg::CNT_W-1:0]  rob_occupancy,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rrrob_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic cfg_we;

  // The port never waits; a write lands in the access cycle.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // The sequencer walks each command through its steps and owns the
  // result valid flag.
  rrrob_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // The datapath holds all rename and reorder state and the result register.
  rrrob_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .sts                (sts),
    .cmd                (cmd),
    .dest_valid         (dest_valid),
    .dest_areg          (dest_areg),
    .src1_valid         (src1_valid),
    .src1_areg          (src1_areg),
    .src2_valid         (src2_valid),
    .src2_areg          (src2_areg),
    .is_branch          (is_branch),
    .mispredicted       (mispredicted),
    .done_rob_index     (done_rob_index),
    .done_preg_valid    (done_preg_valid),
    .done_preg          (done_preg),
    .cfg_we             (cfg_we),
    .cfg_sel            (paddr[2]),
    .cfg_wdata          (pwdata[CNT_W-1:0]),
    .cfg_rdata          (prdata),
    .accepted           (accepted),
    .stall_reason       (stall_reason),
    .src1_preg          (src1_preg),
    .src2_preg          (src2_preg),
    .dest_preg          (dest_preg),
    .rob_slot           (rob_slot),
    .retired_count      (retired_count),
    .retired_branches   (retired_branches),
    .mispredict_retired (mispredict_retired),
    .rob_occupancy      (rob_occupancy)
  );

endmodule
